[hdl/hsvgrb_pkg.sv]
// ----------------------------------------------------------------------------
// hsvgrb_pkg
// Types and constants shared by the hsv to rgb converter with grb packing.
// ----------------------------------------------------------------------------
`default_nettype none

package hsvgrb_pkg;

  localparam int unsigned HUE_W   = 16;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned WORD_W  = 32;

  localparam int unsigned HMOD_W  = 9;   // hue after mod 360
  localparam int unsigned HQ_W    = 8;   // hue / 360, at most 182
  localparam int unsigned FRAC_W  = 6;   // 0..60 position inside a sector
  localparam int unsigned PROD_W  = 14;  // percent times percent
  localparam int unsigned NUM_W   = 20;  // numerators over 600000

  localparam logic [HMOD_W-1:0] HUE_TURN   = 9'd360;
  localparam logic [HMOD_W-1:0] SECTOR_DEG = 9'd60;
  localparam logic [PCT_W-1:0]  PCT_FULL   = 7'd100;
  localparam logic [NUM_W-1:0]  HI_SCALE   = 20'd6000;
  localparam logic [NUM_W-1:0]  LO_SCALE   = 20'd60;

  // ceil(2^32 / 360): exact floor quotient for any 16-bit hue
  localparam int unsigned       HUE_RECIP_W     = 24;
  localparam logic [HUE_RECIP_W-1:0] HUE_RECIP  = 24'd11930465;
  localparam int unsigned       HUE_RECIP_SHIFT = 32;

  // ceil(255 * 2^40 / 600000): exact floor(n * 255 / 600000) for n < 2^20
  localparam int unsigned       LVL_RECIP_W     = 29;
  localparam logic [LVL_RECIP_W-1:0] LVL_RECIP  = 29'd467292442;
  localparam int unsigned       LVL_RECIP_SHIFT = 40;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  typedef struct packed {
    logic [HMOD_W-1:0] hmod;
    logic [PCT_W-1:0]  sat;
    logic [PCT_W-1:0]  val;
  } hue_stage_t;

  typedef struct packed {
    sector_t          sector;
    logic [NUM_W-1:0] n_hi;
    logic [NUM_W-1:0] n_lo;
    logic [NUM_W-1:0] n_mid;
  } mix_stage_t;

endpackage

`default_nettype wire

[hdl/hsvgrb_hue.sv]
// ----------------------------------------------------------------------------
// hsvgrb_hue
// Two stages: clamp percentages, then reduce the hue modulo 360 by reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvgrb_hue (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           up_valid,
  output logic                                up_ready,
  input  wire logic [hsvgrb_pkg::HUE_W-1:0]   hue,
  input  wire logic [hsvgrb_pkg::PCT_W-1:0]   sat,
  input  wire logic [hsvgrb_pkg::PCT_W-1:0]   val,
  output logic                                dn_valid,
  input  wire logic                           dn_ready,
  output hsvgrb_pkg::hue_stage_t              dn_data
);

  localparam int unsigned MUL_W = hsvgrb_pkg::HUE_W + hsvgrb_pkg::HUE_RECIP_W;

  logic                              s1_valid_r;
  logic [hsvgrb_pkg::HQ_W-1:0]       s1_hq_r;
  logic [hsvgrb_pkg::HUE_W-1:0]      s1_hue_r;
  logic [hsvgrb_pkg::PCT_W-1:0]      s1_sat_r;
  logic [hsvgrb_pkg::PCT_W-1:0]      s1_val_r;
  logic                              s2_valid_r;
  hsvgrb_pkg::hue_stage_t            s2_data_r;

  logic                              s1_ready;
  logic                              s2_ready;
  logic [MUL_W-1:0]                  hue_prod;
  logic [hsvgrb_pkg::PCT_W-1:0]      sat_c;
  logic [hsvgrb_pkg::PCT_W-1:0]      val_c;
  logic [hsvgrb_pkg::HUE_W-1:0]      hq_x;
  logic [hsvgrb_pkg::HUE_W-1:0]      hue_diff;

  assign s2_ready = !s2_valid_r || dn_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign up_ready = s1_ready;

  assign sat_c    = (sat > hsvgrb_pkg::PCT_FULL) ? hsvgrb_pkg::PCT_FULL : sat;
  assign val_c    = (val > hsvgrb_pkg::PCT_FULL) ? hsvgrb_pkg::PCT_FULL : val;
  assign hue_prod = MUL_W'(hue) * MUL_W'(hsvgrb_pkg::HUE_RECIP);

  // remainder after the exact quotient
  assign hq_x     = hsvgrb_pkg::HUE_W'(s1_hq_r) * hsvgrb_pkg::HUE_W'(hsvgrb_pkg::HUE_TURN);
  assign hue_diff = s1_hue_r - hq_x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= up_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && up_valid) begin
      s1_hq_r  <= hue_prod[hsvgrb_pkg::HUE_RECIP_SHIFT +: hsvgrb_pkg::HQ_W];
      s1_hue_r <= hue;
      s1_sat_r <= sat_c;
      s1_val_r <= val_c;
    end
    if (s2_ready && s1_valid_r) begin
      s2_data_r.hmod <= hue_diff[hsvgrb_pkg::HMOD_W-1:0];
      s2_data_r.sat  <= s1_sat_r;
      s2_data_r.val  <= s1_val_r;
    end
  end

  assign dn_valid = s2_valid_r;
  assign dn_data  = s2_data_r;

endmodule

`default_nettype wire

[hdl/hsvgrb_mix.sv]
// ----------------------------------------------------------------------------
// hsvgrb_mix
// Two stages: sector and ramp position, then the three numerators over 600000.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvgrb_mix (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    up_valid,
  output logic                         up_ready,
  input  wire hsvgrb_pkg::hue_stage_t  up_data,
  output logic                         dn_valid,
  input  wire logic                    dn_ready,
  output hsvgrb_pkg::mix_stage_t       dn_data
);

  localparam int unsigned REM_W = 7;

  logic                               s3_valid_r;
  hsvgrb_pkg::sector_t                s3_sector_r;
  logic [hsvgrb_pkg::FRAC_W-1:0]      s3_t_r;
  logic [hsvgrb_pkg::PROD_W-1:0]      s3_vs_r;
  logic [hsvgrb_pkg::PROD_W-1:0]      s3_vl_r;
  logic [hsvgrb_pkg::PCT_W-1:0]       s3_val_r;
  logic                               s4_valid_r;
  hsvgrb_pkg::mix_stage_t             s4_data_r;

  logic                               s3_ready;
  logic                               s4_ready;
  hsvgrb_pkg::sector_t                sector;
  logic [hsvgrb_pkg::HMOD_W-1:0]      base;
  logic [hsvgrb_pkg::HMOD_W-1:0]      rem_full;
  logic [REM_W-1:0]                   rem;
  logic [hsvgrb_pkg::FRAC_W-1:0]      mid_dist;
  logic [hsvgrb_pkg::FRAC_W-1:0]      t_pos;
  logic [hsvgrb_pkg::PCT_W-1:0]       sat_inv;
  logic [hsvgrb_pkg::NUM_W-1:0]       n_lo;
  logic [hsvgrb_pkg::NUM_W-1:0]       n_mid;
  logic [hsvgrb_pkg::NUM_W-1:0]       n_hi;

  assign s4_ready = !s4_valid_r || dn_ready;
  assign s3_ready = !s3_valid_r || s4_ready;
  assign up_ready = s3_ready;

  always_comb begin
    if (up_data.hmod < 9'd60) begin
      sector = hsvgrb_pkg::SEC_RED_YEL;
      base   = 9'd0;
    end else if (up_data.hmod < 9'd120) begin
      sector = hsvgrb_pkg::SEC_YEL_GRN;
      base   = 9'd0;
    end else if (up_data.hmod < 9'd180) begin
      sector = hsvgrb_pkg::SEC_GRN_CYN;
      base   = 9'd120;
    end else if (up_data.hmod < 9'd240) begin
      sector = hsvgrb_pkg::SEC_CYN_BLU;
      base   = 9'd120;
    end else if (up_data.hmod < 9'd300) begin
      sector = hsvgrb_pkg::SEC_BLU_MAG;
      base   = 9'd240;
    end else begin
      sector = hsvgrb_pkg::SEC_MAG_RED;
      base   = 9'd240;
    end
  end

  // hue mod 120, then distance from the middle of that 120-degree span
  assign rem_full = up_data.hmod - base;
  assign rem      = rem_full[REM_W-1:0];
  assign mid_dist = (rem >= REM_W'(hsvgrb_pkg::SECTOR_DEG))
                  ? hsvgrb_pkg::FRAC_W'(rem - REM_W'(hsvgrb_pkg::SECTOR_DEG))
                  : hsvgrb_pkg::FRAC_W'(REM_W'(hsvgrb_pkg::SECTOR_DEG) - rem);
  assign t_pos    = hsvgrb_pkg::FRAC_W'(hsvgrb_pkg::SECTOR_DEG) - mid_dist;
  assign sat_inv  = hsvgrb_pkg::PCT_FULL - up_data.sat;

  assign n_lo  = hsvgrb_pkg::NUM_W'(s3_vl_r) * hsvgrb_pkg::LO_SCALE;
  assign n_mid = hsvgrb_pkg::NUM_W'(s3_vs_r) * hsvgrb_pkg::NUM_W'(s3_t_r) + n_lo;
  assign n_hi  = hsvgrb_pkg::NUM_W'(s3_val_r) * hsvgrb_pkg::HI_SCALE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_valid_r <= up_valid;
      end
      if (s4_ready) begin
        s4_valid_r <= s3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && up_valid) begin
      s3_sector_r <= sector;
      s3_t_r      <= t_pos;
      s3_vs_r     <= hsvgrb_pkg::PROD_W'(up_data.val) * hsvgrb_pkg::PROD_W'(up_data.sat);
      s3_vl_r     <= hsvgrb_pkg::PROD_W'(up_data.val) * hsvgrb_pkg::PROD_W'(sat_inv);
      s3_val_r    <= up_data.val;
    end
    if (s4_ready && s3_valid_r) begin
      s4_data_r.sector <= s3_sector_r;
      s4_data_r.n_hi   <= n_hi;
      s4_data_r.n_lo   <= n_lo;
      s4_data_r.n_mid  <= n_mid;
    end
  end

  assign dn_valid = s4_valid_r;
  assign dn_data  = s4_data_r;

endmodule

`default_nettype wire

[hdl/hsvgrb_lvl.sv]
// ----------------------------------------------------------------------------
// hsvgrb_lvl
// Output stage: scales numerators to bytes and routes them by sector.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvgrb_lvl (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             up_valid,
  output logic                                  up_ready,
  input  wire hsvgrb_pkg::mix_stage_t           up_data,
  output logic                                  dn_valid,
  input  wire logic                             dn_ready,
  output logic [hsvgrb_pkg::LEVEL_W-1:0]        red,
  output logic [hsvgrb_pkg::LEVEL_W-1:0]        green,
  output logic [hsvgrb_pkg::LEVEL_W-1:0]        blue
);

  localparam int unsigned MUL_W = hsvgrb_pkg::NUM_W + hsvgrb_pkg::LVL_RECIP_W;

  logic                               s5_valid_r;
  logic [hsvgrb_pkg::LEVEL_W-1:0]     red_r;
  logic [hsvgrb_pkg::LEVEL_W-1:0]     green_r;
  logic [hsvgrb_pkg::LEVEL_W-1:0]     blue_r;

  logic                               s5_ready;
  logic [MUL_W-1:0]                   p_hi;
  logic [MUL_W-1:0]                   p_lo;
  logic [MUL_W-1:0]                   p_mid;
  logic [hsvgrb_pkg::LEVEL_W-1:0]     hi;
  logic [hsvgrb_pkg::LEVEL_W-1:0]     lo;
  logic [hsvgrb_pkg::LEVEL_W-1:0]     mid;
  logic [hsvgrb_pkg::LEVEL_W-1:0]     red_nxt;
  logic [hsvgrb_pkg::LEVEL_W-1:0]     green_nxt;
  logic [hsvgrb_pkg::LEVEL_W-1:0]     blue_nxt;

  assign s5_ready = !s5_valid_r || dn_ready;
  assign up_ready = s5_ready;

  // floor(n * 255 / 600000), exact with the rounded-up reciprocal
  assign p_hi  = MUL_W'(up_data.n_hi)  * MUL_W'(hsvgrb_pkg::LVL_RECIP);
  assign p_lo  = MUL_W'(up_data.n_lo)  * MUL_W'(hsvgrb_pkg::LVL_RECIP);
  assign p_mid = MUL_W'(up_data.n_mid) * MUL_W'(hsvgrb_pkg::LVL_RECIP);
  assign hi    = p_hi[hsvgrb_pkg::LVL_RECIP_SHIFT +: hsvgrb_pkg::LEVEL_W];
  assign lo    = p_lo[hsvgrb_pkg::LVL_RECIP_SHIFT +: hsvgrb_pkg::LEVEL_W];
  assign mid   = p_mid[hsvgrb_pkg::LVL_RECIP_SHIFT +: hsvgrb_pkg::LEVEL_W];

  always_comb begin
    case (up_data.sector)
      hsvgrb_pkg::SEC_RED_YEL: begin
        red_nxt = hi;  green_nxt = mid; blue_nxt = lo;
      end
      hsvgrb_pkg::SEC_YEL_GRN: begin
        red_nxt = mid; green_nxt = hi;  blue_nxt = lo;
      end
      hsvgrb_pkg::SEC_GRN_CYN: begin
        red_nxt = lo;  green_nxt = hi;  blue_nxt = mid;
      end
      hsvgrb_pkg::SEC_CYN_BLU: begin
        red_nxt = lo;  green_nxt = mid; blue_nxt = hi;
      end
      hsvgrb_pkg::SEC_BLU_MAG: begin
        red_nxt = mid; green_nxt = lo;  blue_nxt = hi;
      end
      default: begin
        red_nxt = hi;  green_nxt = lo;  blue_nxt = mid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (s5_ready) begin
      s5_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_ready && up_valid) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign dn_valid = s5_valid_r;
  assign red      = red_r;
  assign green    = green_r;
  assign blue     = blue_r;

endmodule

`default_nettype wire

[hdl/hsv_to_rgb_grb_packer.sv]
// ----------------------------------------------------------------------------
// hsv_to_rgb_grb_packer
// Converts hue / saturation / value items to rgb bytes and a grb led word.
// ----------------------------------------------------------------------------
// Input channel in_*: one item per handshake with hue in degrees (any 16-bit
// value, taken modulo 360), saturation and value in percent (above 100 reads
// as 100). Output channel out_*: red, green and blue bytes plus the led word
// green<<24 | red<<16 | blue<<8 with a zero low byte.
// Five register stages: clamp and hue quotient, hue remainder, sector and
// ramp position, numerators, byte scaling with the output register.
// Items move through the stages in order; one item per clock is sustained
// while out_tready stays high, set by the five stages each taking a new
// item when its successor moves or is empty.
// When out_tready is low the last stage holds its item and the stages behind
// it fill up; empty stages still take items, so in_tready drops only once
// every stage is occupied. No item is lost or repeated across a stall.
// Reset (rst_n low, synchronous) empties the pipeline; there is no other
// state and nothing to configure.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_grb_packer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // hue_degrees[15:0], saturation_pct[22:16],
                                       // value_pct[29:23], zero[31:30]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata   // red_level[7:0], green_level[15:8],
                                       // blue_level[23:16], led_word[55:24]
);

  logic                              hue_valid;
  logic                              hue_ready;
  hsvgrb_pkg::hue_stage_t            hue_data;
  logic                              mix_valid;
  logic                              mix_ready;
  hsvgrb_pkg::mix_stage_t            mix_data;
  logic [hsvgrb_pkg::LEVEL_W-1:0]    red;
  logic [hsvgrb_pkg::LEVEL_W-1:0]    green;
  logic [hsvgrb_pkg::LEVEL_W-1:0]    blue;
  logic [hsvgrb_pkg::WORD_W-1:0]     led_word;

  hsvgrb_hue u_hue (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .hue      (in_tdata[15:0]),
    .sat      (in_tdata[22:16]),
    .val      (in_tdata[29:23]),
    .dn_valid (hue_valid),
    .dn_ready (hue_ready),
    .dn_data  (hue_data)
  );

  hsvgrb_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (hue_valid),
    .up_ready (hue_ready),
    .up_data  (hue_data),
    .dn_valid (mix_valid),
    .dn_ready (mix_ready),
    .dn_data  (mix_data)
  );

  hsvgrb_lvl u_lvl (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mix_valid),
    .up_ready (mix_ready),
    .up_data  (mix_data),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .red      (red),
    .green    (green),
    .blue     (blue)
  );

  assign led_word  = {green, red, blue, 8'h00};
  assign out_tdata = {led_word, blue, green, red};

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hsv to rgb converter with grb led word packing.
// Items go in through the input stream with random gaps, a back-to-back
// burst and a burst against a long output stall. Every accepted item is
// converted by an exact integer model and queued. Each pixel that leaves the
// block is compared field by field with the oldest queued pixel.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned LONG_HOLD  = 100;
  localparam int unsigned DRAIN_WAIT = 10;

  typedef struct {
    logic [hsvgrb_pkg::LEVEL_W-1:0] red;
    logic [hsvgrb_pkg::LEVEL_W-1:0] green;
    logic [hsvgrb_pkg::LEVEL_W-1:0] blue;
    logic [hsvgrb_pkg::WORD_W-1:0]  led;
  } pixel_t;

  class pixel_scoreboard;
    pixel_t      expected_pixels[$];
    int unsigned mismatches = 0;

    // floor(n * 255 / 600000), capped at a full byte
    function automatic logic [hsvgrb_pkg::LEVEL_W-1:0] scale_to_byte(longint unsigned num);
      longint unsigned q;
      q = (num * 255) / 600000;
      if (q > 255) q = 255;
      return q[hsvgrb_pkg::LEVEL_W-1:0];
    endfunction

    function automatic pixel_t convert_hsv(logic [hsvgrb_pkg::HUE_W-1:0] hue,
                                           logic [hsvgrb_pkg::PCT_W-1:0] sat_in,
                                           logic [hsvgrb_pkg::PCT_W-1:0] val_in);
      int unsigned                    sat, val, hmod, rem, mid_dist, ramp;
      longint unsigned                n_hi, n_lo, n_mid;
      logic [hsvgrb_pkg::LEVEL_W-1:0] hi, lo, mid;
      hsvgrb_pkg::sector_t            sector;
      pixel_t                         px;
      sat  = 32'((sat_in > hsvgrb_pkg::PCT_FULL) ? hsvgrb_pkg::PCT_FULL : sat_in);
      val  = 32'((val_in > hsvgrb_pkg::PCT_FULL) ? hsvgrb_pkg::PCT_FULL : val_in);
      hmod = 32'(hue) % 32'(hsvgrb_pkg::HUE_TURN);
      rem  = hmod % (2 * hsvgrb_pkg::SECTOR_DEG);
      mid_dist = (rem >= hsvgrb_pkg::SECTOR_DEG) ? rem - hsvgrb_pkg::SECTOR_DEG
                                                  : hsvgrb_pkg::SECTOR_DEG - rem;
      ramp = hsvgrb_pkg::SECTOR_DEG - mid_dist;
      // numerators of c+m, m and x+m over 600000
      n_hi  = longint'(val) * 6000;
      n_lo  = longint'(hsvgrb_pkg::SECTOR_DEG) * val * (hsvgrb_pkg::PCT_FULL - sat);
      n_mid = longint'(val) * sat * ramp + n_lo;
      hi  = scale_to_byte(n_hi);
      lo  = scale_to_byte(n_lo);
      mid = scale_to_byte(n_mid);
      sector = hsvgrb_pkg::sector_t'(3'(hmod / hsvgrb_pkg::SECTOR_DEG));
      case (sector)
        hsvgrb_pkg::SEC_RED_YEL: begin px.red = hi;  px.green = mid; px.blue = lo;  end
        hsvgrb_pkg::SEC_YEL_GRN: begin px.red = mid; px.green = hi;  px.blue = lo;  end
        hsvgrb_pkg::SEC_GRN_CYN: begin px.red = lo;  px.green = hi;  px.blue = mid; end
        hsvgrb_pkg::SEC_CYN_BLU: begin px.red = lo;  px.green = mid; px.blue = hi;  end
        hsvgrb_pkg::SEC_BLU_MAG: begin px.red = mid; px.green = lo;  px.blue = hi;  end
        default:                 begin px.red = hi;  px.green = lo;  px.blue = mid; end
      endcase
      px.led = {px.green, px.red, px.blue, 8'h00};
      return px;
    endfunction

    function void note_input(logic [31:0] data);
      expected_pixels.push_back(convert_hsv(data[15:0], data[22:16], data[29:23]));
    endfunction

    function void check_field(string name, logic [hsvgrb_pkg::WORD_W-1:0] exp_v,
                              logic [hsvgrb_pkg::WORD_W-1:0] act_v);
      if (exp_v !== act_v) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [55:0] data);
      pixel_t exp_px;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected pixel, expected none, actual %014h", $time, data);
        return;
      end
      exp_px = expected_pixels.pop_front();
      check_field("red_level", hsvgrb_pkg::WORD_W'(exp_px.red),
                  hsvgrb_pkg::WORD_W'(data[7:0]));
      check_field("green_level", hsvgrb_pkg::WORD_W'(exp_px.green),
                  hsvgrb_pkg::WORD_W'(data[15:8]));
      check_field("blue_level", hsvgrb_pkg::WORD_W'(exp_px.blue),
                  hsvgrb_pkg::WORD_W'(data[23:16]));
      check_field("led_word", exp_px.led, data[55:24]);
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  pixel_scoreboard sb = new();
  int unsigned     idle_cycles = 0;
  bit              steady = 1'b0;
  bit              hold_req = 1'b0;
  bit              hold_on = 1'b0;

  hsv_to_rgb_grb_packer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pack_hsv(logic [hsvgrb_pkg::HUE_W-1:0] hue,
                                           logic [hsvgrb_pkg::PCT_W-1:0] sat,
                                           logic [hsvgrb_pkg::PCT_W-1:0] val);
    return {2'b00, val, sat, hue};
  endfunction

  function automatic logic [hsvgrb_pkg::PCT_W-1:0] random_pct();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return hsvgrb_pkg::PCT_W'($urandom_range(0, 100));
    if (r < 85) return ($urandom_range(0, 1) != 0) ? hsvgrb_pkg::PCT_FULL : 7'd0;
    return hsvgrb_pkg::PCT_W'($urandom_range(101, 127));
  endfunction

  function automatic logic [31:0] random_hsv();
    int unsigned                  r;
    logic [hsvgrb_pkg::HUE_W-1:0] hue;
    r = $urandom_range(0, 99);
    if (r < 50) hue = hsvgrb_pkg::HUE_W'($urandom_range(0, 359));
    else if (r < 80) hue = hsvgrb_pkg::HUE_W'($urandom());
    else hue = hsvgrb_pkg::HUE_W'(($urandom_range(0, 6) * hsvgrb_pkg::SECTOR_DEG
                                   + $urandom_range(0, 2) + 359) % 65536);
    return pack_hsv(hue, random_pct(), random_pct());
  endfunction

  task automatic send_item(logic [31:0] data, int unsigned gap);
    in_tdata  <= data;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_hsv(logic [hsvgrb_pkg::HUE_W-1:0] hue,
                          logic [hsvgrb_pkg::PCT_W-1:0] sat,
                          logic [hsvgrb_pkg::PCT_W-1:0] val);
    send_item(pack_hsv(hue, sat, val), pick_gap());
  endtask

  task automatic send_random(int unsigned count, bit no_gaps);
    repeat (count) send_item(random_hsv(), no_gaps ? 0 : pick_gap());
  endtask

  task automatic drain_pixels();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // output side: random stalls, steady stretches and one long hold-off
  initial begin
    int unsigned run_len, stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_on = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
        hold_on  = 1'b0;
      end else if (steady) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        run_len = $urandom_range(1, 12);
        stall   = pick_gap();
        out_tready <= 1'b1;
        repeat (run_len) @(posedge clk);
        if (stall != 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sector edges at full saturation and value
    send_hsv(16'd0, 7'd100, 7'd100);
    send_hsv(16'd59, 7'd100, 7'd100);
    send_hsv(16'd60, 7'd100, 7'd100);
    send_hsv(16'd120, 7'd100, 7'd100);
    send_hsv(16'd180, 7'd100, 7'd100);
    send_hsv(16'd240, 7'd100, 7'd100);
    send_hsv(16'd300, 7'd100, 7'd100);
    send_hsv(16'd359, 7'd100, 7'd100);
    // wrap of the hue and the largest hue
    send_hsv(16'd360, 7'd100, 7'd100);
    send_hsv(16'hFFFF, 7'd127, 7'd127);
    // mid ramp lands on a half step, grey lands on exactly 255
    send_hsv(16'd30, 7'd100, 7'd100);
    send_hsv(16'd90, 7'd0, 7'd100);
    send_hsv(16'd210, 7'd50, 7'd100);
    // clamping of saturation and value
    send_hsv(16'd150, 7'd101, 7'd60);
    send_hsv(16'd270, 7'd127, 7'd101);
    send_hsv(16'd330, 7'd45, 7'd127);
    // black and zero saturation
    send_hsv(16'd0, 7'd0, 7'd0);
    send_hsv(16'd200, 7'd100, 7'd0);
    send_hsv(16'd17, 7'd0, 7'd37);
    // alternating bit patterns
    send_hsv(16'hAAAA, 7'h55, 7'h2A);
    send_hsv(16'h5555, 7'h2A, 7'h55);
    send_hsv(16'd719, 7'd1, 7'd1);
    drain_pixels();

    send_random(300, 1'b0);

    // back-to-back on both sides
    steady = 1'b1;
    send_random(150, 1'b1);
    steady = 1'b0;
    drain_pixels();

    // receiver holds off while items keep coming, so the pipe fills
    hold_req = 1'b1;
    while (!hold_on) @(posedge clk);
    send_random(30, 1'b1);
    drain_pixels();

    send_random(320, 1'b0);
    drain_pixels();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/hsvgrb_pkg.sv
hdl/hsvgrb_hue.sv
hdl/hsvgrb_mix.sv
hdl/hsvgrb_lvl.sv
hdl/hsv_to_rgb_grb_packer.sv
sim/tb_top.sv
